@@ hdl/tmc_pkg.sv @@
package tmc_pkg;

  // Field widths of the command and result transactions
  localparam int CMD_W  = 4;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  // Default screen geometry
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_UP        = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DOWN      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_WRITE_AT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_CELL = 4'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture the input transaction
    logic exec;       // run the command on cursor and single cell
    logic fill;       // write one blank cell of a fill sweep
    logic fill_init;  // fill with the reset attribute
    logic scroll;     // advance one step of the scroll sweep
    logic load_out;   // load the result registers
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_fill;    // command needs a full-screen blank fill
    logic go_scroll;  // command needs a scroll-up sweep
    logic swp_last;   // sweep counter sits on the last cell
  } dp_stat_t;

  // Build a cell: attribute in the high byte, character in the low byte
  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [CHAR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

@@ hdl/tmc_ctrl.sv @@
module tmc_ctrl
  import tmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SCROLL,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Decode commands for the datapath
  always_comb begin
    cmd           = '0;
    cmd.load_in   = in_valid && in_ready_r;
    cmd.exec      = (state_r == S_EXEC);
    cmd.fill      = (state_r == S_FILL) || (state_r == S_INIT);
    cmd.fill_init = (state_r == S_INIT);
    cmd.scroll    = (state_r == S_SCROLL);
    cmd.load_out  = (state_r == S_FINISH) && out_free;
  end

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (stat.swp_last) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          priority if (stat.go_fill) begin
            state_r <= S_FILL;
          end else if (stat.go_scroll) begin
            state_r <= S_SCROLL;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FILL: begin
          if (stat.swp_last) begin
            state_r <= S_FINISH;
          end
        end
        S_SCROLL: begin
          if (stat.swp_last) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Ready only while waiting for a command
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("in_ready high outside idle");

  // A finished transaction shows up on the result side and reopens the input
  a_finish_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && out_free |=> out_valid_r && in_ready_r)
    else $error("finished transaction not presented");

  // No result is presented before the reset clearing pass is over
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !out_valid_r && !in_ready_r)
    else $error("handshake active during clearing pass");

endmodule

@@ hdl/tmc_dpath.sv @@
module tmc_dpath
  import tmc_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CHAR_W-1:0] cfg_text_color,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROW_W-1:0]  in_row_pos,
  input  logic [COL_W-1:0]  in_col_pos,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_cell_valid,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0]    LAST_A  = AW'(CELLS - 1);
  localparam logic [AW-1:0]    SCR_A   = AW'(CELLS - COLS);
  localparam logic [AW-1:0]    COLS_A  = AW'(COLS);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLS - 1);
  localparam logic [ROW_W:0]   ROWS_X  = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]   COLS_X  = (COL_W + 1)'(COLS);

  // Screen store
  logic [CELL_W-1:0] mem [CELLS];

  logic [CHAR_W-1:0] text_color_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ROW_W-1:0]  rp_r;
  logic [COL_W-1:0]  cp_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [AW-1:0]     swp_r;
  logic              pend_vld_r;
  logic [AW-1:0]     pend_addr_r;
  logic              pend_blank_r;
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CELL_W-1:0] out_data_r;
  logic              out_vld_r;

  logic [ROW_W-1:0]  row_nxt;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_t;
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [CHAR_W-1:0] wch;
  logic              we_x;
  logic              rd_x;
  logic              go_fill;
  logic              go_scroll;
  logic              pos_on;
  logic [AW-1:0]     addr_x;
  logic              scr_blank;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [CELL_W-1:0] wd;
  logic [CHAR_W-1:0] fill_attr;

  assign row_inc = {1'b0, cur_row_r} + 1'b1;
  assign col_inc = {1'b0, cur_col_r} + 1'b1;
  assign pos_on  = ({1'b0, rp_r} < ROWS_X) && ({1'b0, cp_r} < COLS_X);

  // Work out the new cursor and the single-cell access of a command
  always_comb begin
    row_nxt   = cur_row_r;
    col_nxt   = cur_col_r;
    row_t     = {1'b0, cur_row_r};
    a_row     = cur_row_r;
    a_col     = cur_col_r;
    wch       = ch_r;
    we_x      = 1'b0;
    rd_x      = 1'b0;
    go_fill   = 1'b0;
    go_scroll = 1'b0;
    unique case (cmd_r)
      CMD_PUT_CHAR: begin
        if (ch_r == NEWLINE_CODE) begin
          col_nxt = '0;
          row_t   = row_inc;
        end else begin
          we_x = 1'b1;
          if (col_inc >= COLS_X) begin
            col_nxt = '0;
            row_t   = row_inc;
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
        end
        if (row_t >= ROWS_X) begin
          row_nxt   = ROW_MAX;
          go_scroll = 1'b1;
        end else begin
          row_nxt = row_t[ROW_W-1:0];
        end
      end
      CMD_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
        go_fill = 1'b1;
      end
      CMD_BACKSPACE: begin
        wch = SPACE_CODE;
        if (cur_col_r != '0) begin
          col_nxt = cur_col_r - 1'b1;
          we_x    = 1'b1;
        end else if (cur_row_r != '0) begin
          row_nxt = cur_row_r - 1'b1;
          col_nxt = COL_MAX;
          we_x    = 1'b1;
        end
        a_row = row_nxt;
        a_col = col_nxt;
      end
      CMD_LEFT: begin
        if (cur_col_r != '0) begin
          col_nxt = cur_col_r - 1'b1;
        end else if (cur_row_r != '0) begin
          row_nxt = cur_row_r - 1'b1;
          col_nxt = COL_MAX;
        end
      end
      CMD_RIGHT: begin
        if (cur_col_r < COL_MAX) begin
          col_nxt = col_inc[COL_W-1:0];
        end else if (cur_row_r < ROW_MAX) begin
          row_nxt = row_inc[ROW_W-1:0];
          col_nxt = '0;
        end
      end
      CMD_UP: begin
        if (cur_row_r != '0) begin
          row_nxt = cur_row_r - 1'b1;
        end
      end
      CMD_DOWN: begin
        if (cur_row_r < ROW_MAX) begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end
      CMD_WRITE_AT: begin
        a_row = rp_r;
        a_col = cp_r;
        we_x  = pos_on;
      end
      CMD_READ_CELL: begin
        a_row = rp_r;
        a_col = cp_r;
        rd_x  = pos_on;
      end
      default: begin
      end
    endcase
  end

  assign addr_x = AW'(a_row) * COLS_A + AW'(a_col);

  // Scroll sweep reads one row ahead; the bottom row becomes blank
  assign scr_blank = (swp_r >= SCR_A);
  assign rd_en     = (cmd.exec && rd_x) || (cmd.scroll && !scr_blank);
  assign rd_addr   = cmd.scroll ? (swp_r + COLS_A) : addr_x;
  assign fill_attr = cmd.fill_init ? RESET_COLOR : text_color_r;

  // Select the one write of this cycle
  always_comb begin
    we = 1'b0;
    wa = addr_x;
    wd = make_cell(wch, text_color_r);
    priority if (pend_vld_r) begin
      we = 1'b1;
      wa = pend_addr_r;
      wd = pend_blank_r ? make_cell(SPACE_CODE, text_color_r) : rd_data_r;
    end else if (cmd.fill) begin
      we = 1'b1;
      wa = swp_r;
      wd = make_cell(SPACE_CODE, fill_attr);
    end else if (cmd.exec && we_x) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  // Screen store ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers: color, cursor, sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      swp_r        <= '0;
      pend_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_color_r <= cfg_text_color;
      end
      if (cmd.exec) begin
        cur_row_r <= row_nxt;
        cur_col_r <= col_nxt;
        swp_r     <= '0;
      end else if (cmd.fill || cmd.scroll) begin
        swp_r <= swp_r + 1'b1;
      end
      pend_vld_r <= cmd.scroll;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      ch_r  <= in_char_code;
      rp_r  <= in_row_pos;
      cp_r  <= in_col_pos;
    end
    if (cmd.exec) begin
      rd_vld_r <= rd_x;
    end
    pend_addr_r  <= swp_r;
    pend_blank_r <= scr_blank;
    if (cmd.load_out) begin
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
      out_data_r <= rd_vld_r ? rd_data_r : '0;
      out_vld_r  <= rd_vld_r;
    end
  end

  assign stat.go_fill   = go_fill;
  assign stat.go_scroll = go_scroll;
  assign stat.swp_last  = (swp_r == LAST_A);

  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_data  = out_data_r;
  assign out_cell_valid = out_vld_r;

  // Cursor never leaves the screen
  a_cursor_on: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_row_r} < ROWS_X) && ({1'b0, cur_col_r} < COLS_X))
    else $error("cursor off screen");

  // A result without a valid read carries zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && !rd_vld_r |=> (out_cell_data == '0) && !out_cell_valid)
    else $error("stale cell data in result");

  // A pending scroll write never collides with a command write
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> !cmd.exec && !cmd.fill)
    else $error("scroll write collides with another write");

endmodule

@@ hdl/text_mode_console_engine.sv @@
// Text-mode console engine: a ROWS x COLS screen of 16-bit cells (attribute
// high byte, character low byte) plus a cursor, driven one command transaction
// at a time; every command returns one result with the cursor after it and,
// for read_cell, the cell read. Timing is set by the single-write-port screen
// memory: a cursor or single-cell command passes through the execute and
// finish states before the next acceptance, clear writes one blank cell per
// cycle, and a put_char that scrolls moves or blanks one cell per cycle.
// After reset a clearing pass writes blank cells with attribute 0x07 before
// the first command is taken; text_color writes are taken at any time and
// apply to later commands.
module text_mode_console_engine
  import tmc_pkg::*;
#(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CHAR_W-1:0] cfg_text_color,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROW_W-1:0]  in_row_pos,
  input  logic [COL_W-1:0]  in_col_pos,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [CELL_W-1:0] out_cell_data,
  output logic              out_cell_valid
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmc_dpath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_text_color (cfg_text_color),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_row_pos     (in_row_pos),
    .in_col_pos     (in_col_pos),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_data  (out_cell_data),
    .out_cell_valid (out_cell_valid),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

@@ dv/text_mode_console_engine_tb.sv @@
`timescale 1ns / 100ps

module text_mode_console_engine_tb;
  import tmc_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = ROWS * COLS;

  // Command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int IDLE_PCT = 33;
  localparam int MAX_REPORTS = 10;

  // One result transaction: cursor after the command plus the cell read
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] data;
    logic              vld;
  } report_t;

  // One line of the directed sequence, repeated reps times
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rp;
    logic [COL_W-1:0]  cp;
    int                reps;
    bit                known;
    report_t           want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CHAR_W-1:0] cfg_text_color;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [CHAR_W-1:0] in_char_code;
  logic [ROW_W-1:0]  in_row_pos;
  logic [COL_W-1:0]  in_col_pos;
  logic              out_valid;
  logic              out_ready;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic [CELL_W-1:0] out_cell_data;
  logic              out_cell_valid;

  // Shadow copy of the console state
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int                shadow_row;
  int                shadow_col;
  logic [CHAR_W-1:0] shadow_color;

  report_t  report_q [$];
  report_t  head_report;
  dir_row_t dir_tbl [$];
  int       err_cnt = 0;
  int       result_idx = 0;
  int       next_gap = 0;
  bit       idling_on = 1'b1;

  text_mode_console_engine #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_text_color (cfg_text_color),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_row_pos     (in_row_pos),
    .in_col_pos     (in_col_pos),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_data  (out_cell_data),
    .out_cell_valid (out_cell_valid)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic log_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("[%0t] result %0d: %s", $time, result_idx, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  // Blank the whole screen with the given attribute
  task automatic blank_screen(input logic [CHAR_W-1:0] attr);
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i] = {attr, SPACE_CODE};
    end
  endtask

  // Move every row up by one and blank the bottom row
  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) begin
      shadow_cells[i] = shadow_cells[i + COLS];
    end
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      shadow_cells[i] = {shadow_color, SPACE_CODE};
    end
  endtask

  // Advance the shadow console by one command and form its result
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_W-1:0] rp, input logic [COL_W-1:0] cp,
                               output report_t rep);
    int r;
    int c;
    int tr;
    int tc;
    r = shadow_row;
    c = shadow_col;
    tr = int'(rp);
    tc = int'(cp);
    rep = '0;
    case (cmd)
      CMD_PUT_CHAR: begin
        if (ch == NEWLINE_CODE) begin
          c = 0;
          r++;
        end else begin
          shadow_cells[r * COLS + c] = {shadow_color, ch};
          c++;
        end
        if (c >= COLS) begin
          c = 0;
          r++;
        end
        if (r >= ROWS) begin
          scroll_screen();
          r = ROWS - 1;
        end
      end
      CMD_CLEAR: begin
        blank_screen(shadow_color);
        r = 0;
        c = 0;
      end
      CMD_BACKSPACE: begin
        if (c > 0 || r > 0) begin
          if (c > 0) begin
            c--;
          end else begin
            r--;
            c = COLS - 1;
          end
          shadow_cells[r * COLS + c] = {shadow_color, SPACE_CODE};
        end
      end
      CMD_LEFT: begin
        if (c > 0) begin
          c--;
        end else if (r > 0) begin
          r--;
          c = COLS - 1;
        end
      end
      CMD_RIGHT: begin
        if (c < COLS - 1) begin
          c++;
        end else if (r < ROWS - 1) begin
          r++;
          c = 0;
        end
      end
      CMD_UP: begin
        if (r > 0) r--;
      end
      CMD_DOWN: begin
        if (r < ROWS - 1) r++;
      end
      CMD_WRITE_AT: begin
        if (tr < ROWS && tc < COLS) begin
          shadow_cells[tr * COLS + tc] = {shadow_color, ch};
        end
      end
      CMD_READ_CELL: begin
        if (tr < ROWS && tc < COLS) begin
          rep.data = shadow_cells[tr * COLS + tc];
          rep.vld = 1'b1;
        end
      end
      default: ;
    endcase
    shadow_row = r;
    shadow_col = c;
    rep.row = r[ROW_W-1:0];
    rep.col = c[COL_W-1:0];
  endtask

  // Drive one command transaction and queue its expected result
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                       input logic [ROW_W-1:0] rp, input logic [COL_W-1:0] cp,
                       input bit known, input report_t known_rep);
    report_t rep;
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_char_code <= ch;
    in_row_pos <= rp;
    in_col_pos <= cp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(cmd, ch, rp, cp, rep);
    report_q.push_back(known ? known_rep : rep);
    // decide now whether the next transaction follows back to back
    next_gap = 0;
    while (idling_on && $urandom_range(0, 99) < IDLE_PCT) next_gap++;
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // Drop valid, then wait until every expected result has arrived
  task automatic finish_phase();
    if (next_gap == 0) in_valid <= 1'b0;
    next_gap = 0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_color(input logic [CHAR_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_text_color <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_color = v;
  endtask

  // Random command, printing most often, with cursor moves, reads, writes, clears and unused codes mixed in
  task automatic pick_command(output logic [CMD_W-1:0] cmd, output logic [CHAR_W-1:0] ch,
                              output logic [ROW_W-1:0] rp, output logic [COL_W-1:0] cp);
    int sel;
    sel = $urandom_range(0, 99);
    ch = CHAR_W'($urandom_range(0, 255));
    rp = ROW_W'($urandom_range(0, 31));
    cp = COL_W'($urandom_range(0, 127));
    if (sel < 40) begin
      cmd = CMD_PUT_CHAR;
      if ($urandom_range(0, 4) == 0) ch = NEWLINE_CODE;
    end else if (sel < 50) cmd = CMD_WRITE_AT;
    else if (sel < 65) cmd = CMD_READ_CELL;
    else if (sel < 72) cmd = CMD_DOWN;
    else if (sel < 75) cmd = CMD_UP;
    else if (sel < 79) cmd = CMD_LEFT;
    else if (sel < 84) cmd = CMD_RIGHT;
    else if (sel < 92) cmd = CMD_BACKSPACE;
    else if (sel < 94) cmd = CMD_CLEAR;
    else cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    // keep most targeted accesses on screen
    if ((cmd == CMD_WRITE_AT || cmd == CMD_READ_CELL) && $urandom_range(0, 4) != 0) begin
      rp = ROW_W'($urandom_range(0, ROWS - 1));
      cp = COL_W'($urandom_range(0, COLS - 1));
    end
  endtask

  function automatic dir_row_t dr(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                  input int rp, input int cp,
                                  input int reps, input int known, input int row,
                                  input int col, input int data, input int vld);
    dir_row_t d;
    d.cmd = cmd;
    d.ch = ch;
    d.rp = rp[ROW_W-1:0];
    d.cp = cp[COL_W-1:0];
    d.reps = reps;
    d.known = known[0];
    d.want.row = row[ROW_W-1:0];
    d.want.col = col[COL_W-1:0];
    d.want.data = data[CELL_W-1:0];
    d.want.vld = vld[0];
    return d;
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        log_error($sformatf("unexpected result row %0d col %0d data 0x%0h valid %0b",
                            out_cursor_row, out_cursor_col, out_cell_data, out_cell_valid));
      end else begin
        head_report = report_q.pop_front();
        check_field("cursor_row", 32'(out_cursor_row), 32'(head_report.row));
        check_field("cursor_col", 32'(out_cursor_col), 32'(head_report.col));
        check_field("cell_data", 32'(out_cell_data), 32'(head_report.data));
        check_field("cell_valid", 32'(out_cell_valid), 32'(head_report.vld));
      end
      result_idx++;
    end
    out_ready <= idling_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rp;
    logic [COL_W-1:0]  cp;
    logic [CHAR_W-1:0] color;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_text_color = '0;
    in_valid = 1'b0;
    in_command = CMD_PUT_CHAR;
    in_char_code = '0;
    in_row_pos = '0;
    in_col_pos = '0;
    out_ready = 1'b0;
    shadow_color = RESET_COLOR;
    shadow_row = 0;
    shadow_col = 0;
    blank_screen(RESET_COLOR);

    // Directed sequence from the reset state, attribute 0x07
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, 0, 0, 1, 1, 0, 0, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'hFF, 31, 127, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 1, COLS - 1, 1, 1, 0, 0, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_LEFT, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_BACKSPACE, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_UP, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_UNUSED_LAST, 8'hFF, 31, 127, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_UNUSED_FIRST, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    // high character byte must not leak into the attribute
    dir_tbl.push_back(dr(CMD_PUT_CHAR, 8'hFF, 0, 0, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, 0, 0, 1, 1, 0, 1, 16'h07FF, 1));
    // newline through write_at is stored raw
    dir_tbl.push_back(dr(CMD_WRITE_AT, NEWLINE_CODE, 3, 5, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, 3, 5, 1, 1, 0, 1, 16'h070A, 1));
    // off-screen writes are dropped
    dir_tbl.push_back(dr(CMD_WRITE_AT, 8'h41, ROWS, 0, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_WRITE_AT, 8'h00, 0, COLS, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_WRITE_AT, 8'h41, 31, 127, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, 1, 0, 1, 1, 0, 1, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 1, COLS - 1, 1, 1, 0, 1, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_PUT_CHAR, NEWLINE_CODE, 0, 0, 1, 1, 1, 0, 0, 0));
    // backspace at column zero, right at last column, left at column zero
    dir_tbl.push_back(dr(CMD_BACKSPACE, 8'h00, 0, 0, 1, 1, 0, COLS - 1, 0, 0));
    dir_tbl.push_back(dr(CMD_RIGHT, 8'h00, 0, 0, 1, 1, 1, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_LEFT, 8'h00, 0, 0, 1, 1, 0, COLS - 1, 0, 0));
    // walk to the last cell, then push against the bottom and right edges
    dir_tbl.push_back(dr(CMD_DOWN, 8'h00, 0, 0, ROWS - 1, 0, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_DOWN, 8'h00, 0, 0, 1, 1, ROWS - 1, COLS - 1, 0, 0));
    dir_tbl.push_back(dr(CMD_RIGHT, 8'h00, 0, 0, 1, 1, ROWS - 1, COLS - 1, 0, 0));
    // wrap off the last cell and scroll
    dir_tbl.push_back(dr(CMD_PUT_CHAR, 8'h41, 0, 0, 1, 1, ROWS - 1, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 2, COLS - 1, 1, 1, ROWS - 1, 0,
                         16'h0741, 1));
    dir_tbl.push_back(dr(CMD_PUT_CHAR, 8'h5A, 0, 0, 1, 1, ROWS - 1, 1, 0, 0));
    // newline on the bottom row scrolls too
    dir_tbl.push_back(dr(CMD_PUT_CHAR, NEWLINE_CODE, 0, 0, 1, 1, ROWS - 1, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 2, 0, 1, 1, ROWS - 1, 0, 16'h075A, 1));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 1, 0, 1, 1, ROWS - 1, 0, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_UP, 8'h00, 0, 0, 3, 0, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_CLEAR, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, ROWS - 2, 0, 1, 1, 0, 0, 16'h0720, 1));
    dir_tbl.push_back(dr(CMD_PUT_CHAR, 8'h42, 0, 0, 1, 1, 0, 1, 0, 0));
    dir_tbl.push_back(dr(CMD_BACKSPACE, 8'h00, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_tbl.push_back(dr(CMD_READ_CELL, 8'h00, 0, 0, 1, 1, 0, 0, 16'h0720, 1));

    // Hold reset, then release at a clock edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      repeat (dir_tbl[i].reps) begin
        issue(dir_tbl[i].cmd, dir_tbl[i].ch, dir_tbl[i].rp, dir_tbl[i].cp,
              dir_tbl[i].known, dir_tbl[i].want);
      end
    end
    finish_phase();

    // Random phases, each under a new attribute; one phase runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) color = 8'h00;
      else if (ph == 1) color = 8'hFF;
      else color = CHAR_W'($urandom_range(0, 255));
      set_color(color);
      idling_on = (ph != 3);
      repeat (ITEMS_PER_PHASE) begin
        pick_command(cmd, ch, rp, cp);
        issue(cmd, ch, rp, cp, 1'b0, '0);
      end
      finish_phase();
    end

    repeat (20) @(posedge clk);
    if (report_q.size() != 0) begin
      log_error($sformatf("%0d expected results never arrived", report_q.size()));
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
